/* rtl/pbc_pkg.sv */
package pbc_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] KIND_QUAL = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// configuration register indexes
	localparam int          CFG_IDX_W        = 2;
	localparam logic [1:0]  CFG_QUALITY_LIMIT = 2'd0;
	localparam logic [1:0]  CFG_DROP_ENDS     = 2'd1;
	localparam logic [1:0]  CFG_DROP_STARTS   = 2'd2;

	// pileup characters
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] DEC_BASE = 8'd10;

	// character classes: 0..3 forward bases, 4..7 reverse bases
	localparam logic [3:0] CLS_A_FWD = 4'd0;
	localparam logic [3:0] CLS_END   = 4'd8;
	localparam logic [3:0] CLS_STAR  = 4'd9;
	localparam logic [3:0] CLS_N_FWD = 4'd10;
	localparam logic [3:0] CLS_N_REV = 4'd11;
	localparam logic [3:0] CLS_DEL   = 4'd12;
	localparam logic [3:0] CLS_INS   = 4'd13;
	localparam logic [3:0] BASE_NONE = 4'd15;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// one input transaction
	typedef struct packed {
		logic [7:0] ref_base;
		logic [7:0] chr;
		logic [1:0] kind;
	} item_t;

	function automatic logic [3:0] classify(input logic [7:0] c);
		logic [3:0] cls;
		unique case (c)
			8'h41: cls = 4'd0;
			8'h43: cls = 4'd1;
			8'h47: cls = 4'd2;
			8'h54: cls = 4'd3;
			8'h61: cls = 4'd4;
			8'h63: cls = 4'd5;
			8'h67: cls = 4'd6;
			8'h74: cls = 4'd7;
			CH_DOLLAR: cls = CLS_END;
			CH_STAR: cls = CLS_STAR;
			8'h4E: cls = CLS_N_FWD;
			8'h6E: cls = CLS_N_REV;
			CH_MINUS: cls = CLS_DEL;
			CH_PLUS: cls = CLS_INS;
			default: cls = CLS_A_FWD;
		endcase
		return cls;
	endfunction

	// reverse-strand form of the reference base
	function automatic logic [7:0] lower_ref(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h41: r = 8'h61;
			8'h43: r = 8'h63;
			8'h47: r = 8'h67;
			8'h54: r = 8'h74;
			8'h4E: r = 8'h6E;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

/* rtl/pbc_qual_buf.sv */
module pbc_qual_buf #(
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// one write port, one registered read port with write forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/pileup_base_counter_core.sv */
// Pileup base counter: quality bytes (tuser kind 0) fill a buffer of MAX_DEPTH
// entries, pileup characters (kind 1) are parsed and counted per base and
// strand, and an end item (kind 2) sends one 128-bit result with the saturated
// counts and clears the position. One transaction is accepted every clock; the
// input stalls only while an end item waits behind a result that has not been
// taken. Each item passes through the input register, and an end result is
// registered again in the result register before it is presented on the master
// side. The rate is set by the single parse step between input and result
// register, which reads the next quality byte from a prefetched buffer read
// port. The buffer needs no clearing pass after reset: entries are valid once
// loaded.
module pileup_base_counter_core #(
	parameter int MAX_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // char_byte, reference_base
	input  logic [1:0]                    s_axis_tuser,  // item_kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [127:0]                  m_axis_tdata,  // count_a, count_c, count_g,
	                                                     // count_t, forward_a, forward_c,
	                                                     // forward_g, forward_t
	input  logic                          cfg_we,
	input  logic [pbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import pbc_pkg::*;

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [AW-1:0] PTR_LAST = AW'(MAX_DEPTH - 1);

	// parse modes
	localparam logic [2:0] M_NORMAL    = 3'd0;
	localparam logic [2:0] M_MAPQ      = 3'd1;
	localparam logic [2:0] M_SKIPBASE  = 3'd2;
	localparam logic [2:0] M_STARTBASE = 3'd3;
	localparam logic [2:0] M_DIGITS    = 3'd4;
	localparam logic [2:0] M_INDELSKIP = 3'd5;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [7:0] quality_limit_q;
	logic       drop_ends_q;
	logic       drop_starts_q;

	// stage registers
	logic   s1_valid;
	item_t  item_s1;
	logic   s1_fire;
	logic   out_valid_q;
	logic [127:0] out_data_q;

	// position state
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [15:0]   tot_q [4];
	logic [15:0]   tot_d [4];
	logic [15:0]   fwd_q [4];
	logic [15:0]   fwd_d [4];
	logic [3:0]    last_q, last_d;
	logic [2:0]    mode_q, mode_d;
	logic [15:0]   indel_q, indel_d;

	logic       wr_en;
	logic [7:0] qual;
	logic [7:0] eff_chr;
	logic [3:0] cls;
	logic [19:0] indel_prod;
	logic       is_end;

	assign is_end = (item_s1.kind == KIND_END);
	assign s1_fire = s1_valid && (!is_end || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid || s1_fire;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// quality buffer
	pbc_qual_buf #(
		.DEPTH(MAX_DEPTH)
	) u_qual_buf (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_ptr_q),
		.wr_data(item_s1.chr),
		.rd_addr(rd_ptr_d),
		.rd_data(qual)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_limit_q <= '0;
			drop_ends_q <= 1'b0;
			drop_starts_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUALITY_LIMIT: quality_limit_q <= cfg_data;
				CFG_DROP_ENDS: drop_ends_q <= cfg_data[0];
				CFG_DROP_STARTS: drop_starts_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// character after '.' and ',' substitution
	always_comb begin
		if (item_s1.chr == CH_DOT) begin
			eff_chr = item_s1.ref_base;
		end else if (item_s1.chr == CH_COMMA) begin
			eff_chr = lower_ref(item_s1.ref_base);
		end else begin
			eff_chr = item_s1.chr;
		end
	end
	assign cls = classify(eff_chr);

	// indel length times ten plus the digit
	assign indel_prod = ({4'b0, indel_q} << 3) + ({4'b0, indel_q} << 1)
		+ {16'b0, item_s1.chr[3:0]};

	// parse step
	always_comb begin
		logic       do_normal;
		logic       do_base;
		logic       consume;
		logic [3:0] tot_inc;
		logic [3:0] fwd_inc;
		logic [3:0] tot_dec;
		logic [3:0] fwd_dec;
		logic [15:0] indel_m1;

		tot_d = tot_q;
		fwd_d = fwd_q;
		last_d = last_q;
		mode_d = mode_q;
		indel_d = indel_q;
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		wr_en = 1'b0;
		do_normal = 1'b0;
		do_base = 1'b0;
		consume = 1'b0;
		tot_inc = '0;
		fwd_inc = '0;
		tot_dec = '0;
		fwd_dec = '0;
		indel_m1 = indel_q - 16'd1;

		if (s1_fire && (item_s1.kind == KIND_QUAL)) begin
			wr_en = 1'b1;
			wr_ptr_d = ptr_inc(wr_ptr_q);
		end

		// mode handling
		if (s1_fire && (item_s1.kind == KIND_CHAR)) begin
			unique case (mode_q)
				M_MAPQ: mode_d = drop_starts_q ? M_SKIPBASE : M_STARTBASE;
				M_SKIPBASE: begin
					consume = 1'b1;
					mode_d = M_NORMAL;
				end
				M_STARTBASE: begin
					mode_d = M_NORMAL;
					do_base = 1'b1;
				end
				M_DIGITS: begin
					if ((item_s1.chr >= CH_ZERO) && (item_s1.chr <= CH_NINE)) begin
						indel_d = (indel_prod > {4'b0, CNT_MAX}) ? CNT_MAX : indel_prod[15:0];
					end else if (indel_q == '0) begin
						mode_d = M_NORMAL;
						do_normal = 1'b1;
					end else begin
						indel_d = indel_m1;
						mode_d = (indel_m1 != '0) ? M_INDELSKIP : M_NORMAL;
					end
				end
				M_INDELSKIP: begin
					if (indel_q != '0) begin
						indel_d = indel_m1;
					end
					if ((indel_q == '0) || (indel_m1 == '0)) begin
						mode_d = M_NORMAL;
					end
				end
				default: begin
					mode_d = M_NORMAL;
					do_normal = 1'b1;
				end
			endcase
		end

		// read-start mark or base
		if (do_normal) begin
			if (item_s1.chr == CH_CARET) begin
				mode_d = M_MAPQ;
			end else begin
				do_base = 1'b1;
			end
		end

		// base classes
		if (do_base) begin
			if (cls < CLS_END) begin
				consume = 1'b1;
				if (qual >= quality_limit_q) begin
					last_d = cls;
					tot_inc[cls[1:0]] = 1'b1;
					fwd_inc[cls[1:0]] = !cls[2];
				end else begin
					last_d = BASE_NONE;
				end
			end else if (cls == CLS_END) begin
				if (drop_ends_q && (last_q < CLS_END)) begin
					tot_dec[last_q[1:0]] = 1'b1;
					fwd_dec[last_q[1:0]] = !last_q[2];
				end
				last_d = BASE_NONE;
			end else if (cls <= CLS_N_REV) begin
				consume = 1'b1;
				last_d = BASE_NONE;
			end else begin
				mode_d = M_DIGITS;
				indel_d = '0;
			end
		end

		if (consume) begin
			rd_ptr_d = ptr_inc(rd_ptr_q);
		end

		// saturating counter lanes
		for (int i = 0; i < 4; i++) begin
			if (tot_inc[i] && (tot_q[i] != CNT_MAX)) begin
				tot_d[i] = tot_q[i] + 16'd1;
			end
			if (fwd_inc[i] && (fwd_q[i] != CNT_MAX)) begin
				fwd_d[i] = fwd_q[i] + 16'd1;
			end
			if (tot_dec[i] && (tot_q[i] != '0)) begin
				tot_d[i] = tot_q[i] - 16'd1;
			end
			if (fwd_dec[i] && (fwd_q[i] != '0)) begin
				fwd_d[i] = fwd_q[i] - 16'd1;
			end
		end

		// end of position clears everything but the stored bytes
		if (s1_fire && is_end) begin
			for (int i = 0; i < 4; i++) begin
				tot_d[i] = '0;
				fwd_d[i] = '0;
			end
			last_d = BASE_NONE;
			mode_d = M_NORMAL;
			indel_d = '0;
			rd_ptr_d = '0;
			wr_ptr_d = '0;
		end
	end

	// control and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			for (int i = 0; i < 4; i++) begin
				tot_q[i] <= '0;
				fwd_q[i] <= '0;
			end
			last_q <= BASE_NONE;
			mode_q <= M_NORMAL;
			indel_q <= '0;
		end else begin
			if (s_axis_tready) begin
				s1_valid <= s_axis_tvalid;
			end
			if (s1_fire && is_end) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			tot_q <= tot_d;
			fwd_q <= fwd_d;
			last_q <= last_d;
			mode_q <= mode_d;
			indel_q <= indel_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{ref_base: s_axis_tdata[15:8], chr: s_axis_tdata[7:0],
				kind: s_axis_tuser};
		end
		if (s1_fire && is_end) begin
			out_data_q <= {fwd_q[3], fwd_q[2], fwd_q[1], fwd_q[0],
				tot_q[3], tot_q[2], tot_q[1], tot_q[0]};
		end
	end

endmodule

/* rtl/pbc_checker.sv */
module pbc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	import pbc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// forward count never exceeds the total of its base
	a_fwd_le_tot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[79:64] <= m_axis_tdata[15:0])
			&& (m_axis_tdata[95:80] <= m_axis_tdata[31:16])
			&& (m_axis_tdata[111:96] <= m_axis_tdata[47:32])
			&& (m_axis_tdata[127:112] <= m_axis_tdata[63:48]))
		else $error("forward count above total");

	// a fresh result comes from an accepted end transaction, through the input and result registers
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_END), 2))
		else $error("result without end transaction");

	// with no result pending the input side never stalls
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind pileup_base_counter_core pbc_checker u_pbc_checker (.*);

/* dv/pileup_base_counter_core_tb.sv */
module pileup_base_counter_core_tb;
	import pbc_pkg::*;

	localparam int DEPTH = 256;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [3:0] REV_OFS = 4'd4;
	localparam logic [3:0] BASE_C = 4'd1;
	localparam logic [3:0] BASE_G = 4'd2;
	localparam logic [3:0] BASE_T = 4'd3;
	localparam logic [7:0] LOWER_BIT = 8'h20;

	typedef enum logic [2:0] {
		PM_NORMAL,
		PM_MAPQ,
		PM_SKIP_BASE,
		PM_START_BASE,
		PM_DIGITS,
		PM_INDEL_SKIP
	} parse_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// pending input transactions and expected count results
	item_t pending[$];
	logic [127:0] counts_due[$];
	item_t tx_item;
	int n_put = 0;
	int n_errors = 0;
	int stall_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	string base_chars = "ACGTacgtNn*";
	string ref_chars = "ACGTN";
	string field_names [8] = '{"count_a", "count_c", "count_g", "count_t",
		"forward_a", "forward_c", "forward_g", "forward_t"};

	// predicted block state and configuration
	logic [7:0] qual_mem [DEPTH];
	logic [7:0] qual_wr;
	logic [7:0] qual_rd;
	logic [15:0] tot_cnt [4];
	logic [15:0] fwd_cnt [4];
	logic [3:0] recent_base;
	parse_mode_e parse_st;
	logic [15:0] indel_left;
	logic [7:0] lim_cfg;
	logic drop_ends_cfg;
	logic drop_starts_cfg;

	pileup_base_counter_core #(
		.MAX_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// pileup character to base class
	function automatic logic [3:0] char_class(input logic [7:0] c);
		case (c)
			"A": return CLS_A_FWD;
			"C": return BASE_C;
			"G": return BASE_G;
			"T": return BASE_T;
			"a": return CLS_A_FWD | REV_OFS;
			"c": return BASE_C | REV_OFS;
			"g": return BASE_G | REV_OFS;
			"t": return BASE_T | REV_OFS;
			"N": return CLS_N_FWD;
			"n": return CLS_N_REV;
			CH_DOLLAR: return CLS_END;
			CH_STAR: return CLS_STAR;
			CH_MINUS: return CLS_DEL;
			CH_PLUS: return CLS_INS;
			default: return CLS_A_FWD;
		endcase
	endfunction

	// reverse strand form of the reference, only for A C G T N
	function automatic logic [7:0] to_reverse(input logic [7:0] c);
		if (c == "A" || c == "C" || c == "G" || c == "T" || c == "N")
			return c | LOWER_BIT;
		return c;
	endfunction

	task automatic clear_position();
		for (int i = 0; i < 4; i++) begin
			tot_cnt[i] = '0;
			fwd_cnt[i] = '0;
		end
		qual_wr = '0;
		qual_rd = '0;
		recent_base = BASE_NONE;
		parse_st = PM_NORMAL;
		indel_left = '0;
	endtask

	// one base-slot character: count, undo, skip or start of an indel
	task automatic take_base(input logic [7:0] c, input logic [7:0] rb);
		logic [7:0] ch;
		logic [3:0] cls;
		logic [7:0] q;
		logic [1:0] b;
		ch = c;
		if (c == CH_DOT)
			ch = rb;
		else if (c == CH_COMMA)
			ch = to_reverse(rb);
		cls = char_class(ch);
		if (cls < CLS_END) begin
			q = qual_mem[qual_rd];
			qual_rd++;
			if (q >= lim_cfg) begin
				b = cls[1:0];
				recent_base = cls;
				if (tot_cnt[b] != CNT_MAX)
					tot_cnt[b]++;
				if (cls < REV_OFS && fwd_cnt[b] != CNT_MAX)
					fwd_cnt[b]++;
			end else begin
				recent_base = BASE_NONE;
			end
		end else if (cls == CLS_END) begin
			if (drop_ends_cfg && recent_base < CLS_END) begin
				b = recent_base[1:0];
				if (tot_cnt[b] != 0)
					tot_cnt[b]--;
				if (recent_base < REV_OFS && fwd_cnt[b] != 0)
					fwd_cnt[b]--;
			end
			recent_base = BASE_NONE;
		end else if (cls <= CLS_N_REV) begin
			qual_rd++;
			recent_base = BASE_NONE;
		end else begin
			parse_st = PM_DIGITS;
			indel_left = '0;
		end
	endtask

	task automatic take_normal(input logic [7:0] c, input logic [7:0] rb);
		if (c == CH_CARET)
			parse_st = PM_MAPQ;
		else
			take_base(c, rb);
	endtask

	// parser step for one pileup character
	task automatic take_char(input logic [7:0] c, input logic [7:0] rb);
		int v;
		case (parse_st)
			PM_MAPQ: begin
				parse_st = drop_starts_cfg ? PM_SKIP_BASE : PM_START_BASE;
			end
			PM_SKIP_BASE: begin
				qual_rd++;
				parse_st = PM_NORMAL;
			end
			PM_START_BASE: begin
				parse_st = PM_NORMAL;
				take_base(c, rb);
			end
			PM_DIGITS: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					v = int'(indel_left) * int'(DEC_BASE) + int'(c - CH_ZERO);
					indel_left = (v > int'(CNT_MAX)) ? CNT_MAX : v[15:0];
				end else if (indel_left == 0) begin
					parse_st = PM_NORMAL;
					take_normal(c, rb);
				end else begin
					indel_left--;
					parse_st = (indel_left != 0) ? PM_INDEL_SKIP : PM_NORMAL;
				end
			end
			PM_INDEL_SKIP: begin
				if (indel_left != 0)
					indel_left--;
				if (indel_left == 0)
					parse_st = PM_NORMAL;
			end
			default: begin
				parse_st = PM_NORMAL;
				take_normal(c, rb);
			end
		endcase
	endtask

	// predict one accepted input transaction
	task automatic count_step(input logic [1:0] kind, input logic [7:0] c, input logic [7:0] rb);
		logic [127:0] res;
		case (kind)
			KIND_QUAL: begin
				qual_mem[qual_wr] = c;
				qual_wr++;
			end
			KIND_CHAR: take_char(c, rb);
			KIND_END: begin
				for (int i = 0; i < 4; i++) begin
					res[16*i +: 16] = tot_cnt[i];
					res[64+16*i +: 16] = fwd_cnt[i];
				end
				counts_due.push_back(res);
				clear_position();
			end
			default: ;
		endcase
	endtask

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= 50)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_counts(input logic [127:0] got);
		logic [127:0] want;
		if (counts_due.size() == 0) begin
			report($sformatf("result %h with none expected", got));
		end else begin
			want = counts_due.pop_front();
			for (int i = 0; i < 8; i++)
				if (got[16*i +: 16] !== want[16*i +: 16])
					report($sformatf("%s got %0d expected %0d", field_names[i],
						got[16*i +: 16], want[16*i +: 16]));
		end
	endtask

	// stimulus helpers
	task automatic put(input logic [1:0] k, input logic [7:0] c, input logic [7:0] r);
		item_t it;
		it.kind = k;
		it.chr = c;
		it.ref_base = r;
		pending.push_back(it);
		if (k != KIND_NONE)
			n_put++;
	endtask

	task automatic put_chars(input string s, input logic [7:0] rb);
		for (int i = 0; i < s.len(); i++)
			put(KIND_CHAR, s[i], rb);
	endtask

	function automatic logic [7:0] pick_quality();
		int q;
		case ($urandom_range(3))
			0, 1: q = int'(lim_cfg) + int'($urandom_range(2)) - 1;
			2: q = int'($urandom_range(255));
			default: q = $urandom_range(1) ? 255 : 0;
		endcase
		if (q < 0)
			q = 0;
		else if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	function automatic logic [7:0] pick_base();
		int r;
		r = $urandom_range(15);
		if (r < 4)
			return CH_DOT;
		else if (r < 7)
			return CH_COMMA;
		else if (r < 14)
			return base_chars[$urandom_range(10)];
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_ref();
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return ref_chars[$urandom_range(4)];
	endfunction

	// stray transactions of any kind and content
	task automatic add_noise();
		case ($urandom_range(3))
			0: put(KIND_QUAL, 8'($urandom), 8'($urandom));
			1: put(KIND_CHAR, 8'($urandom), 8'($urandom));
			2: put(KIND_NONE, 8'($urandom), 8'($urandom));
			default: put(KIND_END, 8'($urandom), 8'($urandom));
		endcase
	endtask

	// one read: optional start mark, base, optional indel and end mark
	task automatic add_read(input logic [7:0] rb);
		int len;
		if ($urandom_range(99) < 12) begin
			put(KIND_CHAR, CH_CARET, rb);
			put(KIND_CHAR, 8'($urandom), rb);
		end
		put(KIND_CHAR, pick_base(), rb);
		if ($urandom_range(99) < 10) begin
			put(KIND_CHAR, $urandom_range(1) ? CH_PLUS : CH_MINUS, rb);
			len = ($urandom_range(5) == 0) ? $urandom_range(10, 19) : $urandom_range(0, 4);
			if (len >= 10)
				put(KIND_CHAR, 8'(int'(CH_ZERO) + len / 10), rb);
			if (len != 0)
				put(KIND_CHAR, 8'(int'(CH_ZERO) + len % 10), rb);
			repeat (len) put(KIND_CHAR, pick_base(), rb);
		end
		if ($urandom_range(99) < 12)
			put(KIND_CHAR, CH_DOLLAR, rb);
		if ($urandom_range(99) < 8)
			add_noise();
	endtask

	task automatic add_position();
		int depth;
		logic [7:0] rb;
		depth = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 12);
		rb = pick_ref();
		repeat (depth) put(KIND_QUAL, pick_quality(), rb);
		for (int i = 0; i < depth; i++)
			add_read(rb);
		put(KIND_END, 8'($urandom), 8'($urandom));
	endtask

	task automatic set_idle(input int m);
		case (m)
			0: begin tx_idle_pct = 33; rx_idle_pct = 60; end
			1: begin tx_idle_pct = 60; rx_idle_pct = 33; end
			default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
		endcase
	endtask

	// register writes on consecutive edges, only while the block is idle
	task automatic write_config(input logic [7:0] limit, input logic ends, input logic starts);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_QUALITY_LIMIT;
		cfg_data <= limit;
		lim_cfg = limit;
		@(posedge clk);
		cfg_index <= CFG_DROP_ENDS;
		cfg_data <= {7'($urandom), ends};
		drop_ends_cfg = ends;
		@(posedge clk);
		cfg_index <= CFG_DROP_STARTS;
		cfg_data <= {7'($urandom), starts};
		drop_starts_cfg = starts;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every transaction is accepted and every result checked
	task automatic drain();
		do @(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || counts_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int idle, input logic [7:0] limit, input logic ends,
		input logic starts, input int n_items, input bit with_hold);
		int target;
		set_idle(idle);
		write_config(limit, ends, starts);
		target = n_put + n_items;
		while (n_put < target)
			add_position();
		if (with_hold) begin
			repeat (40) @(posedge clk);
			hold_req <= hold_req + 1;
		end
		drain();
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				tx_item = pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {tx_item.ref_base, tx_item.chr};
				s_axis_tuser <= tx_item.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				count_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
			if (m_axis_tvalid && m_axis_tready)
				check_counts(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(pending.size() == 0 && !s_axis_tvalid && counts_due.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++)
			qual_mem[i] = '0;
		lim_cfg = '0;
		drop_ends_cfg = 1'b0;
		drop_starts_cfg = 1'b0;
		clear_position();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: buffer wrap, every character class, indels, marks
		set_idle(0);
		write_config(8'd30, 1'b1, 1'b0);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data <= 8'd0;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < DEPTH + 4; i++)
			put(KIND_QUAL, (i % 4 == 3) ? 8'd29 : 8'(30 + i % 200), "G");
		put_chars("ACG$Tacgt$.,*NnX^!^^~A-A+2ACG", "G");
		put(KIND_CHAR, CH_DOT, "X");
		put(KIND_CHAR, CH_COMMA, "N");
		put(KIND_CHAR, CH_COMMA, "X");
		put(KIND_NONE, 8'hFF, 8'hFF);
		put_chars("+999999T", "G");
		put(KIND_END, 8'h00, 8'h00);
		put(KIND_END, 8'hFF, 8'hFF);
		drain();

		// random positions over several settings
		run_phase(0, 8'd0, 1'b0, 1'b0, 70, 1'b0);
		run_phase(0, 8'd255, 1'b1, 1'b1, 70, 1'b1);
		run_phase(1, 8'($urandom), 1'b1, 1'b0, 70, 1'b0);
		run_phase(1, 8'($urandom), 1'b0, 1'b1, 70, 1'b1);
		run_phase(2, 8'($urandom_range(20, 40)), 1'b1, 1'b1, 70, 1'b0);
		run_phase(2, 8'($urandom), 1'($urandom), 1'($urandom), 70, 1'b0);

		if (n_errors == 0 && counts_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
